// ----- sv/fct_pkg.sv -----
// Shared constants, codes and record types of the frustum cull tester.
package fct_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int DATA_W          = 32;
    localparam int RADIUS_W        = 31;
    localparam int SLOT_W          = 3;
    localparam int PLANE_COUNT     = 6;
    localparam int NEAR_PLANE      = PLANE_COUNT - 1;
    localparam int BOX_CORNERS     = 8;
    localparam int CNT_W           = 4;
    localparam int CNT_MAX         = (2 ** CNT_W) - 1;
    localparam int QUEUE_DEPTH     = 8;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W          = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_PLANE     = 2'd0,
        KIND_POINT     = 2'd1,
        KIND_BOX       = 2'd2,
        KIND_BOX_WHOLE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        VERDICT_OUTSIDE   = 2'd0,
        VERDICT_INSIDE    = 2'd1,
        VERDICT_NEAR_ONLY = 2'd2,
        VERDICT_WHOLE     = 2'd3
    } t_verdict;

    // Classified item: for point tests the flags mark failing planes, for box
    // corners they mark planes that have the corner strictly in front.
    typedef struct packed {
        t_kind                    kind;
        logic                     last;
        logic                     near_mode;
        logic [PLANE_COUNT-1:0]   flags;
        logic signed [DATA_W-1:0] near_dist;
    } t_rec;

endpackage

// ----- sv/fct_if.sv -----
// Valid/ready channel interfaces for the test items and the verdicts.
interface fct_in_if;
    import fct_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               kind;
    logic [SLOT_W-1:0]        plane_slot;
    logic signed [DATA_W-1:0] normal_x;
    logic signed [DATA_W-1:0] normal_y;
    logic signed [DATA_W-1:0] normal_z;
    logic signed [DATA_W-1:0] plane_offset_in;
    logic signed [DATA_W-1:0] coord_x;
    logic signed [DATA_W-1:0] coord_y;
    logic signed [DATA_W-1:0] coord_z;
    logic [RADIUS_W-1:0]      radius;
    logic                     near_mode;
    logic                     last_corner;

    modport source (
        output valid, kind, plane_slot, normal_x, normal_y, normal_z, plane_offset_in,
        output coord_x, coord_y, coord_z, radius, near_mode, last_corner,
        input  ready
    );
    modport sink (
        input  valid, kind, plane_slot, normal_x, normal_y, normal_z, plane_offset_in,
        input  coord_x, coord_y, coord_z, radius, near_mode, last_corner,
        output ready
    );
endinterface

interface fct_out_if;
    import fct_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               verdict;
    logic signed [DATA_W-1:0] near_distance;

    modport source (output valid, verdict, near_distance, input ready);
    modport sink (input valid, verdict, near_distance, output ready);
endinterface

// ----- sv/frustum_cull_tester.sv -----
// Top level of the six-plane frustum cull tester.
// Path: an accepted test transaction passes pipeline registers A to D, the queue and the
// output register, and the queue and output register can hold it under back-pressure.
// Throughput: one transaction per cycle when not stalled; an eight-entry queue between the
// distance pipeline and the verdict stage holds a slot for every transaction in flight.
// Reset clears the pipeline, the queue and the box counters; the plane store is not
// cleared and must be written before use.
module frustum_cull_tester #(
    parameter int COORD_WIDTH = fct_pkg::COORD_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fct_in_if.sink    i_req,
    fct_out_if.source o_rsp
);
    import fct_pkg::*;

    logic              push;
    t_rec              push_rec;
    logic              pop;
    logic              head_valid;
    t_rec              head_rec;
    logic [QLVL_W-1:0] queue_level;

    fct_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (i_req),
        .i_queue_level (queue_level),
        .o_push        (push),
        .o_push_rec    (push_rec)
    );

    fct_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_rec   (push_rec),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head_rec   (head_rec),
        .o_level      (queue_level)
    );

    fct_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head_rec   (head_rec),
        .o_pop        (pop),
        .o_rsp        (o_rsp)
    );

endmodule

// ----- sv/fct_front.sv -----
// Front end: plane store, six parallel plane-distance pipelines and classification.
module fct_front #(
    parameter int COORD_WIDTH = fct_pkg::COORD_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    fct_in_if.sink                       i_req,
    input  logic [fct_pkg::QLVL_W-1:0]   i_queue_level,
    output logic                         o_push,
    output fct_pkg::t_rec                o_push_rec
);
    import fct_pkg::*;

    localparam int PW     = 2 * COORD_WIDTH - 16;
    localparam int DW     = PW + 2;
    localparam int SW     = (DW > DATA_W + 1) ? DW : DATA_W + 1;
    localparam int FILL_W = QLVL_W + 1;

    typedef struct packed {
        t_kind               kind;
        logic                last;
        logic                near_mode;
        logic [RADIUS_W-1:0] radius;
    } t_tag;

    logic signed [COORD_WIDTH-1:0] r_nx [PLANE_COUNT];
    logic signed [COORD_WIDTH-1:0] r_ny [PLANE_COUNT];
    logic signed [COORD_WIDTH-1:0] r_nz [PLANE_COUNT];
    logic signed [COORD_WIDTH-1:0] r_d  [PLANE_COUNT];

    logic                          r_a_valid;
    t_tag                          r_a_tag;
    logic signed [PW-1:0]          r_a_px [PLANE_COUNT];
    logic signed [PW-1:0]          r_a_py [PLANE_COUNT];
    logic signed [PW-1:0]          r_a_pz [PLANE_COUNT];
    logic signed [COORD_WIDTH-1:0] r_a_d  [PLANE_COUNT];

    logic                          r_b_valid;
    t_tag                          r_b_tag;
    logic signed [PW:0]            r_b_ab [PLANE_COUNT];
    logic signed [PW:0]            r_b_cd [PLANE_COUNT];

    logic                          r_c_valid;
    t_tag                          r_c_tag;
    logic signed [DW-1:0]          r_c_dist [PLANE_COUNT];

    logic                          r_d_valid;
    t_rec                          r_d_rec;

    logic                          accept;
    logic                          ready;
    logic [2:0]                    inflight;
    logic [FILL_W-1:0]             fill;
    logic signed [COORD_WIDTH-1:0] px;
    logic signed [COORD_WIDTH-1:0] py;
    logic signed [COORD_WIDTH-1:0] pz;
    logic signed [2*COORD_WIDTH-1:0] full_x [PLANE_COUNT];
    logic signed [2*COORD_WIDTH-1:0] full_y [PLANE_COUNT];
    logic signed [2*COORD_WIDTH-1:0] full_z [PLANE_COUNT];
    logic signed [SW-1:0]          dist_ext [PLANE_COUNT];
    logic signed [SW-1:0]          neg_rad;
    logic [PLANE_COUNT-1:0]        fail;
    logic [PLANE_COUNT-1:0]        in_front;
    logic [SW-DATA_W:0]            near_top;
    logic signed [DATA_W-1:0]      near_sat;

    // Every transaction in flight holds a queue entry in reserve.
    assign inflight = 3'(r_a_valid) + 3'(r_b_valid) + 3'(r_c_valid) + 3'(r_d_valid);
    assign fill     = FILL_W'(i_queue_level) + FILL_W'(inflight);
    assign ready    = fill < FILL_W'(QUEUE_DEPTH);
    assign i_req.ready = ready;
    assign accept   = i_req.valid && ready;

    assign px = i_req.coord_x[COORD_WIDTH-1:0];
    assign py = i_req.coord_y[COORD_WIDTH-1:0];
    assign pz = i_req.coord_z[COORD_WIDTH-1:0];

    always_comb begin
        for (int i = 0; i < PLANE_COUNT; i++) begin
            full_x[i] = r_nx[i] * px;
            full_y[i] = r_ny[i] * py;
            full_z[i] = r_nz[i] * pz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (t_kind'(i_req.kind) == KIND_PLANE)
            && (i_req.plane_slot < SLOT_W'(PLANE_COUNT))) begin
            r_nx[i_req.plane_slot] <= i_req.normal_x[COORD_WIDTH-1:0];
            r_ny[i_req.plane_slot] <= i_req.normal_y[COORD_WIDTH-1:0];
            r_nz[i_req.plane_slot] <= i_req.normal_z[COORD_WIDTH-1:0];
            r_d[i_req.plane_slot]  <= i_req.plane_offset_in[COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            r_a_valid <= accept && (t_kind'(i_req.kind) != KIND_PLANE);
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_tag.kind      <= t_kind'(i_req.kind);
        r_a_tag.last      <= i_req.last_corner;
        r_a_tag.near_mode <= i_req.near_mode;
        r_a_tag.radius    <= i_req.radius;
        r_b_tag           <= r_a_tag;
        r_c_tag           <= r_b_tag;
        for (int i = 0; i < PLANE_COUNT; i++) begin
            r_a_px[i]   <= full_x[i][2*COORD_WIDTH-1:16];
            r_a_py[i]   <= full_y[i][2*COORD_WIDTH-1:16];
            r_a_pz[i]   <= full_z[i][2*COORD_WIDTH-1:16];
            r_a_d[i]    <= r_d[i];
            r_b_ab[i]   <= (PW+1)'(r_a_px[i]) + (PW+1)'(r_a_py[i]);
            r_b_cd[i]   <= (PW+1)'(r_a_pz[i]) + (PW+1)'(r_a_d[i]);
            r_c_dist[i] <= DW'(r_b_ab[i]) + DW'(r_b_cd[i]);
        end
    end

    always_comb begin
        neg_rad = -SW'(r_c_tag.radius);
        for (int i = 0; i < PLANE_COUNT; i++) begin
            dist_ext[i] = SW'(r_c_dist[i]);
            fail[i]     = dist_ext[i] < neg_rad;
            in_front[i] = !dist_ext[i][SW-1] && (dist_ext[i] != '0);
        end
        near_top = dist_ext[NEAR_PLANE][SW-1:DATA_W-1];
        if ((&near_top) || (~|near_top)) begin
            near_sat = dist_ext[NEAR_PLANE][DATA_W-1:0];
        end else if (near_top[SW-DATA_W]) begin
            near_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            near_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_rec.kind      <= r_c_tag.kind;
        r_d_rec.last      <= r_c_tag.last;
        r_d_rec.near_mode <= r_c_tag.near_mode;
        r_d_rec.flags     <= (r_c_tag.kind == KIND_POINT) ? fail : in_front;
        r_d_rec.near_dist <= near_sat;
    end

    assign o_push     = r_d_valid;
    assign o_push_rec = r_d_rec;

endmodule

// ----- sv/fct_queue.sv -----
// Short queue of classified transactions between the front and back ends.
module fct_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  fct_pkg::t_rec               i_push_rec,
    input  logic                        i_pop,
    output logic                        o_head_valid,
    output fct_pkg::t_rec               o_head_rec,
    output logic [fct_pkg::QLVL_W-1:0]  o_level
);
    import fct_pkg::*;

    t_rec              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QLVL_W-1:0] r_level;
    logic [QLVL_W-1:0] n_level;

    assign n_level = r_level + QLVL_W'(i_push) - QLVL_W'(i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_rec;
        end
    end

    assign o_head_valid = r_level != '0;
    assign o_head_rec   = r_mem[r_rd_ptr];
    assign o_level      = r_level;

endmodule

// ----- sv/fct_back.sv -----
// Back end: box corner counters, verdict decision and output register.
module fct_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head_valid,
    input  fct_pkg::t_rec  i_head_rec,
    output logic           o_pop,
    fct_out_if.source      o_rsp
);
    import fct_pkg::*;

    logic [CNT_W-1:0]         r_cnt [PLANE_COUNT];
    logic [CNT_W-1:0]         n_cnt [PLANE_COUNT];
    logic                     r_out_valid;
    logic                     n_out_valid;
    t_verdict                 r_verdict;
    t_verdict                 n_verdict;
    logic signed [DATA_W-1:0] r_near;
    logic signed [DATA_W-1:0] n_near;

    logic                     pop;
    logic                     emit;
    logic                     any_zero;
    logic                     all_full;
    logic [CNT_W-1:0]         inc_cnt [PLANE_COUNT];

    assign pop   = i_head_valid && (!r_out_valid || o_rsp.ready);
    assign o_pop = pop;

    always_comb begin
        any_zero = 1'b0;
        all_full = 1'b1;
        for (int i = 0; i < PLANE_COUNT; i++) begin
            if (i_head_rec.flags[i] && (r_cnt[i] != CNT_W'(CNT_MAX))) begin
                inc_cnt[i] = r_cnt[i] + CNT_W'(1);
            end else begin
                inc_cnt[i] = r_cnt[i];
            end
            if (inc_cnt[i] == '0) begin
                any_zero = 1'b1;
            end
            if (inc_cnt[i] != CNT_W'(BOX_CORNERS)) begin
                all_full = 1'b0;
            end
        end
    end

    always_comb begin
        n_cnt       = r_cnt;
        n_verdict   = r_verdict;
        n_near      = r_near;
        emit        = 1'b0;
        case (i_head_rec.kind) inside
            KIND_BOX, KIND_BOX_WHOLE: begin
                emit = i_head_rec.last;
                for (int i = 0; i < PLANE_COUNT; i++) begin
                    n_cnt[i] = i_head_rec.last ? '0 : inc_cnt[i];
                end
                n_near = '0;
                if (any_zero) begin
                    n_verdict = VERDICT_OUTSIDE;
                end else if ((i_head_rec.kind == KIND_BOX_WHOLE) && all_full) begin
                    n_verdict = VERDICT_WHOLE;
                end else begin
                    n_verdict = VERDICT_INSIDE;
                end
            end
            KIND_POINT: begin
                emit   = 1'b1;
                n_near = i_head_rec.near_dist;
                if (|i_head_rec.flags[NEAR_PLANE-1:0]) begin
                    n_verdict = VERDICT_OUTSIDE;
                end else if (i_head_rec.flags[NEAR_PLANE]) begin
                    n_verdict = i_head_rec.near_mode ? VERDICT_NEAR_ONLY : VERDICT_OUTSIDE;
                end else begin
                    n_verdict = VERDICT_INSIDE;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        if (!pop) begin
            n_cnt     = r_cnt;
            n_verdict = r_verdict;
            n_near    = r_near;
        end
        n_out_valid = (r_out_valid && !o_rsp.ready) || (pop && emit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int i = 0; i < PLANE_COUNT; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && emit) begin
            r_verdict <= n_verdict;
            r_near    <= n_near;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.verdict       = r_verdict;
    assign o_rsp.near_distance = r_near;

endmodule
